### design/rpsc_pkg.sv
// Shared types, widths and constants for the roll PID servo controller.
// No dependencies; every other design file imports this package.
package rpsc_pkg;

  // Field and datapath widths
  localparam int SampleW  = 17;
  localparam int ErrW     = 17;
  localparam int DiffW    = 18;
  localparam int DerivW   = 24;
  localparam int GainW    = 16;
  localparam int ILimW    = 15;
  localparam int PulseW   = 12;
  localparam int DegW     = 12;
  localparam int PhaseW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int IntegW   = 32;
  localparam int IncW     = 28;
  localparam int KpProdW  = 33;
  localparam int KiProdW  = 33;
  localparam int KdProdW  = 40;
  localparam int CtrlW    = 41;
  localparam int CorrW    = 17;

  // Divide by 50: halve, then multiply by ceil(2^36 / 25) and drop 36 bits
  localparam int          RecipW     = 32;
  localparam logic [31:0] Recip25    = 32'd2748779070;
  localparam int          Div50Shift = 36;

  // Reset values of the configuration registers and held pulse
  localparam logic signed [GainW-1:0]  KpReset    = -16'sd1164;
  localparam logic signed [GainW-1:0]  KiReset    = -16'sd281;
  localparam logic signed [GainW-1:0]  KdReset    = 16'sd0;
  localparam logic        [ILimW-1:0]  ILimReset  = 15'd12800;
  localparam logic        [PulseW-1:0] TrimReset  = 12'd1410;
  localparam logic        [PulseW-1:0] PMinReset  = 12'd600;
  localparam logic        [PulseW-1:0] PMaxReset  = 12'd2400;
  localparam logic        [PulseW-1:0] CLimReset  = 12'd300;
  localparam logic        [PulseW-1:0] HeldReset  = 12'd1410;

  typedef enum logic [PhaseW-1:0] {
    PHASE_CAL  = 2'd0,
    PHASE_HOLD = 2'd1,
    PHASE_RUN  = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP   = 3'd0,
    CFG_KI   = 3'd1,
    CFG_KD   = 3'd2,
    CFG_ILIM = 3'd3,
    CFG_TRIM = 3'd4,
    CFG_PMIN = 3'd5,
    CFG_PMAX = 3'd6,
    CFG_CLIM = 3'd7
  } cfg_idx_e;

endpackage

### design/rpsc_in_if.sv
// Request channel of the roll PID servo controller: valid/ready plus sample and phase.
// Depends on rpsc_pkg.
interface rpsc_in_if;
  import rpsc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] roll_sample;
  logic        [PhaseW-1:0]  phase;

  modport source (output valid, output roll_sample, output phase, input ready);
  modport sink   (input valid, input roll_sample, input phase, output ready);
endinterface

### design/rpsc_out_if.sv
// Result channel of the roll PID servo controller: valid/ready plus pulse and degrees.
// Depends on rpsc_pkg.
interface rpsc_out_if;
  import rpsc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic        [PulseW-1:0] pulse_width;
  logic signed [DegW-1:0]   control_degrees;

  modport source (output valid, output pulse_width, output control_degrees, input ready);
  modport sink   (input valid, input pulse_width, input control_degrees, output ready);
endinterface

### design/rpsc_div50.sv
// Registered signed divide by 50, truncating toward zero, via reciprocal multiply.
// Depends on rpsc_pkg.
module rpsc_div50 (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [rpsc_pkg::KiProdW-1:0] prod_i,
  output logic signed [rpsc_pkg::IncW-1:0]    quot_o
);
  import rpsc_pkg::*;

  localparam int MagW  = KiProdW - 1;
  localparam int HalfW = MagW - 1;
  localparam int WideW = HalfW + RecipW;
  localparam int QW    = WideW - Div50Shift;

  logic                      neg;
  logic signed [KiProdW-1:0] prod_neg;
  logic        [MagW-1:0]    mag;
  logic        [HalfW-1:0]   half;
  logic        [WideW-1:0]   wide;
  logic        [QW-1:0]      q;
  logic signed [IncW-1:0]    quot_d;
  logic signed [IncW-1:0]    quot_q;

  always_comb begin
    neg      = prod_i[KiProdW-1];
    prod_neg = -prod_i;
    // magnitude is at most 2^31, so it fits unsigned in one bit less
    mag      = neg ? prod_neg[MagW-1:0] : prod_i[MagW-1:0];
    half     = mag[MagW-1:1];
    wide     = WideW'(half) * WideW'(Recip25);
    q        = wide[WideW-1:Div50Shift];
    quot_d   = neg ? -IncW'(q) : IncW'(q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

### design/roll_pid_servo_controller_core.sv
// Roll PID servo controller: offset, error, PID with anti-windup, pulse clamp.
// Takes one request per cycle unless a waiting result stalls the pipeline.
// Five stages (input, error, products, divide by 50, result); the integrator and held pulse
// close their loop inside the last stage. Reset clears the pipeline and state, loads
// the default gains and limits, and sets the held pulse to 1410 us.
// Depends on rpsc_pkg, rpsc_in_if, rpsc_out_if and rpsc_div50.
module roll_pid_servo_controller_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  rpsc_in_if.sink                            in_i,
  rpsc_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [rpsc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [rpsc_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import rpsc_pkg::*;

  // Configuration registers
  logic signed [GainW-1:0]  kp_q, ki_q, kd_q;
  logic        [ILimW-1:0]  ilim_q;
  logic        [PulseW-1:0] trim_q, pmin_q, pmax_q, clim_q;

  // Persistent state
  logic signed [SampleW-1:0] offset_q;
  logic signed [ErrW-1:0]    prev_err_q;
  logic signed [IntegW-1:0]  integ_q;
  logic        [PulseW-1:0]  held_q;

  // Pipeline stage registers
  logic                      a_v_q, b_v_q, c_v_q, d_v_q, e_v_q;
  logic signed [SampleW-1:0] a_sample_q;
  logic        [PhaseW-1:0]  a_phase_q, b_phase_q, c_phase_q, d_phase_q;
  logic signed [ErrW-1:0]    b_err_q;
  logic signed [DerivW-1:0]  b_deriv_q;
  logic signed [KpProdW-1:0] c_p_q, d_p_q;
  logic signed [KiProdW-1:0] c_i_q;
  logic signed [KdProdW-1:0] c_d_q, d_d_q;
  logic signed [IncW-1:0]    d_inc;
  logic        [PulseW-1:0]  e_pulse_q;
  logic signed [DegW-1:0]    e_deg_q;

  logic free_a, free_b, free_c, free_d, free_e;

  // Stage moves: a slot takes a new item when empty or when its item moves on
  assign free_e     = !e_v_q || out_o.ready;
  assign free_d     = !d_v_q || free_e;
  assign free_c     = !c_v_q || free_d;
  assign free_b     = !b_v_q || free_c;
  assign free_a     = !a_v_q || free_b;
  assign in_i.ready = free_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= KpReset;
      ki_q   <= KiReset;
      kd_q   <= KdReset;
      ilim_q <= ILimReset;
      trim_q <= TrimReset;
      pmin_q <= PMinReset;
      pmax_q <= PMaxReset;
      clim_q <= CLimReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KP:   kp_q   <= cfg_wdata_i;
        CFG_KI:   ki_q   <= cfg_wdata_i;
        CFG_KD:   kd_q   <= cfg_wdata_i;
        CFG_ILIM: ilim_q <= cfg_wdata_i[ILimW-1:0];
        CFG_TRIM: trim_q <= cfg_wdata_i[PulseW-1:0];
        CFG_PMIN: pmin_q <= cfg_wdata_i[PulseW-1:0];
        CFG_PMAX: pmax_q <= cfg_wdata_i[PulseW-1:0];
        CFG_CLIM: clim_q <= cfg_wdata_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- error and derivative ----------------
  logic signed [SampleW-1:0] off_sel;
  logic signed [DiffW-1:0]   err_raw;
  logic signed [ErrW-1:0]    err_d;
  logic signed [DiffW-1:0]   err_diff;
  logic signed [DerivW-1:0]  diff_x;
  logic signed [DerivW-1:0]  deriv_d;

  always_comb begin
    off_sel  = (phase_e'(a_phase_q) == PHASE_CAL) ? a_sample_q : offset_q;
    err_raw  = {off_sel[SampleW-1], off_sel} - {a_sample_q[SampleW-1], a_sample_q};
    // saturate to the 17-bit error range
    if (err_raw[DiffW-1] != err_raw[DiffW-2]) begin
      err_d = err_raw[DiffW-1] ? {1'b1, {(ErrW-1){1'b0}}} : {1'b0, {(ErrW-1){1'b1}}};
    end else begin
      err_d = err_raw[ErrW-1:0];
    end
    err_diff = {err_d[ErrW-1], err_d} - {prev_err_q[ErrW-1], prev_err_q};
    diff_x   = {{(DerivW-DiffW){err_diff[DiffW-1]}}, err_diff};
    // times 50 = 32 + 16 + 2
    deriv_d  = (diff_x <<< 5) + (diff_x <<< 4) + (diff_x <<< 1);
  end

  // ---------------- result stage: integrator loop and pulse ----------------
  logic signed [IntegW:0]   integ_sum, lim_hi, lim_lo, integ_cl;
  logic signed [IntegW-1:0] integ_c, integ_d;
  logic signed [CtrlW-1:0]  ctrl;
  logic signed [CtrlW-17:0] ctrl_hi, ctrl_tr;
  logic signed [CtrlW-17:0] deg_max, deg_min;
  logic signed [DegW-1:0]   deg_d;
  logic signed [CorrW-1:0]  deg_x, corr, clim_p, clim_n;
  logic signed [CorrW-1:0]  pulse_raw, pmin_x, pmax_x, pulse_c;
  logic        [PulseW-1:0] pulse_d;
  logic signed [IntegW-1:0] force_pos;

  always_comb begin
    integ_sum = {integ_q[IntegW-1], integ_q} + (IntegW+1)'(d_inc);
    lim_hi    = {{(IntegW+1-ILimW-8){1'b0}}, ilim_q, 8'd0};
    lim_lo    = -lim_hi;
    if (integ_sum > lim_hi) begin
      integ_cl = lim_hi;
    end else if (integ_sum < lim_lo) begin
      integ_cl = lim_lo;
    end else begin
      integ_cl = integ_sum;
    end
    integ_c = integ_cl[IntegW-1:0];

    ctrl    = CtrlW'(d_p_q) + CtrlW'(integ_c) + CtrlW'(d_d_q);
    // divide by 65536 truncating toward zero
    ctrl_hi = ctrl[CtrlW-1:16];
    ctrl_tr = ctrl_hi + {{(CtrlW-17){1'b0}}, (ctrl[CtrlW-1] && (ctrl[15:0] != 16'd0))};
    deg_max = (CtrlW-16)'(2047);
    deg_min = -(CtrlW-16)'(2048);
    if (ctrl_tr > deg_max) begin
      deg_d = {1'b0, {(DegW-1){1'b1}}};
    end else if (ctrl_tr < deg_min) begin
      deg_d = {1'b1, {(DegW-1){1'b0}}};
    end else begin
      deg_d = ctrl_tr[DegW-1:0];
    end

    deg_x     = CorrW'(deg_d);
    corr      = (deg_x <<< 3) + (deg_x <<< 1);
    clim_p    = {{(CorrW-PulseW){1'b0}}, clim_q};
    clim_n    = -clim_p;
    force_pos = {{(IntegW-PulseW-16){1'b0}}, clim_q, 16'd0};
    // anti-windup: a correction past its limit pins the integrator
    if (corr > clim_p) begin
      integ_d = force_pos;
    end else if (corr < clim_n) begin
      integ_d = -force_pos;
    end else begin
      integ_d = integ_c;
    end

    if (phase_e'(d_phase_q) == PHASE_RUN) begin
      pulse_raw = {{(CorrW-PulseW){1'b0}}, trim_q} + corr;
    end else begin
      pulse_raw = {{(CorrW-PulseW){1'b0}}, held_q};
    end
    pmin_x  = {{(CorrW-PulseW){1'b0}}, pmin_q};
    pmax_x  = {{(CorrW-PulseW){1'b0}}, pmax_q};
    pulse_c = (pulse_raw < pmin_x) ? pmin_x : pulse_raw;
    pulse_c = (pulse_c > pmax_x) ? pmax_x : pulse_c;
    pulse_d = pulse_c[PulseW-1:0];
  end

  // ---------------- control: valids and state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q      <= 1'b0;
      b_v_q      <= 1'b0;
      c_v_q      <= 1'b0;
      d_v_q      <= 1'b0;
      e_v_q      <= 1'b0;
      offset_q   <= '0;
      prev_err_q <= '0;
      integ_q    <= '0;
      held_q     <= HeldReset;
    end else begin
      if (free_a) a_v_q <= in_i.valid;
      if (free_b) b_v_q <= a_v_q;
      if (free_c) c_v_q <= b_v_q;
      if (free_d) d_v_q <= c_v_q;
      if (free_e) e_v_q <= d_v_q;
      if (free_b && a_v_q) begin
        if (phase_e'(a_phase_q) == PHASE_CAL) begin
          offset_q <= a_sample_q;
        end
        prev_err_q <= err_d;
      end
      if (free_e && d_v_q) begin
        integ_q <= integ_d;
        held_q  <= pulse_d;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (free_a && in_i.valid) begin
      a_sample_q <= in_i.roll_sample;
      a_phase_q  <= in_i.phase;
    end
    if (free_b && a_v_q) begin
      b_err_q   <= err_d;
      b_deriv_q <= deriv_d;
      b_phase_q <= a_phase_q;
    end
    if (free_c && b_v_q) begin
      c_p_q     <= KpProdW'(kp_q) * KpProdW'(b_err_q);
      c_i_q     <= KiProdW'(ki_q) * KiProdW'(b_err_q);
      c_d_q     <= KdProdW'(kd_q) * KdProdW'(b_deriv_q);
      c_phase_q <= b_phase_q;
    end
    if (free_d && c_v_q) begin
      d_p_q     <= c_p_q;
      d_d_q     <= c_d_q;
      d_phase_q <= c_phase_q;
    end
    if (free_e && d_v_q) begin
      e_pulse_q <= pulse_d;
      e_deg_q   <= deg_d;
    end
  end

  rpsc_div50 u_div50 (
    .clk_i  (clk_i),
    .en_i   (free_d && c_v_q),
    .prod_i (c_i_q),
    .quot_o (d_inc)
  );

  assign out_o.valid           = e_v_q;
  assign out_o.pulse_width     = e_pulse_q;
  assign out_o.control_degrees = e_deg_q;

endmodule

### design/rpsc_checker.sv
// Port-level checks for the roll PID servo controller, bound to the top level.
// Depends on rpsc_pkg and roll_pid_servo_controller_core.
module rpsc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [rpsc_pkg::PulseW-1:0]       pulse_width_i,
  input logic signed [rpsc_pkg::DegW-1:0]  control_degrees_i
);
  import rpsc_pkg::*;

  localparam int          Depth  = 5;
  localparam int          CntW   = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);

  logic [CntW-1:0] inflight_q;
  logic [CntW-1:0] inflight_d;

  always_comb begin
    inflight_d = inflight_q;
    if (in_valid_i && in_ready_i) inflight_d = inflight_d + 1'b1;
    if (out_valid_i && out_ready_i) inflight_d = inflight_d - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(pulse_width_i) && $stable(control_degrees_i))
    else $error("stalled result changed");

  // every result belongs to an accepted request
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != '0)
    else $error("result without a pending request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= DepthC)
    else $error("more requests in flight than pipeline stages");

  // back pressure only from a result that waits
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("request stalled with no waiting result");

endmodule

bind roll_pid_servo_controller_core rpsc_checker u_rpsc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .pulse_width_i     (out_o.pulse_width),
  .control_degrees_i (out_o.control_degrees)
);

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for roll_pid_servo_controller_core: a directed table, then random
// requests under several gain and limit settings and flow-control mixes, checked by a PID model.
// Depends on rpsc_pkg, rpsc_in_if, rpsc_out_if and the design under test.
module tb_top;
  import rpsc_pkg::*;

  localparam logic [PhaseW-1:0] PHASE_SPARE = 2'd3;
  localparam int    QuietLimit      = 4000;
  localparam int    DrainCycles     = 16;
  localparam int    ItemsPerSetting = 60;
  localparam int    SettingCount    = 8;
  localparam longint TicksPerSec    = 50;
  localparam longint UsPerDegree    = 10;
  localparam longint Q16One         = 65536;

  typedef struct {
    logic        [PulseW-1:0] pulse;
    logic signed [DegW-1:0]   deg;
  } servo_out_t;

  typedef struct {
    int                sample;
    logic [PhaseW-1:0] ph;
    bit                typed;
    int                pulse;
    int                deg;
  } table_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  rpsc_in_if  req_ch ();
  rpsc_out_if rsp_ch ();

  roll_pid_servo_controller_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (req_ch),
    .out_o       (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model copy of the configuration and loop state
  longint kp_gain, ki_gain, kd_gain, ilim_q8, trim_us, pmin_us, pmax_us, clim_us;
  longint roll_zero, last_err, integ_q16, held_us;

  servo_out_t pulse_queue[$];
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;

  table_row_t step_table [21] = '{
    '{0,      PHASE_CAL,   1'b1, 1410, 0},
    '{0,      PHASE_RUN,   1'b1, 1410, 0},
    '{256,    PHASE_RUN,   1'b0, 0,    0},
    '{-256,   PHASE_RUN,   1'b0, 0,    0},
    '{46080,  PHASE_RUN,   1'b0, 0,    0},
    '{-46080, PHASE_RUN,   1'b0, 0,    0},
    '{46080,  PHASE_HOLD,  1'b0, 0,    0},
    '{65535,  PHASE_RUN,   1'b0, 0,    0},
    '{-65536, PHASE_RUN,   1'b0, 0,    0},
    '{-65536, PHASE_CAL,   1'b0, 0,    0},
    '{65535,  PHASE_RUN,   1'b0, 0,    0},   // error saturates low
    '{65535,  PHASE_HOLD,  1'b0, 0,    0},
    '{65535,  PHASE_CAL,   1'b0, 0,    0},
    '{-65536, PHASE_RUN,   1'b0, 0,    0},   // error saturates high
    '{-65536, PHASE_SPARE, 1'b0, 0,    0},
    '{12800,  PHASE_SPARE, 1'b0, 0,    0},
    '{0,      PHASE_CAL,   1'b0, 0,    0},
    '{1000,   PHASE_RUN,   1'b0, 0,    0},
    '{1000,   PHASE_RUN,   1'b0, 0,    0},   // zero derivative
    '{-4096,  PHASE_HOLD,  1'b0, 0,    0},
    '{0,      PHASE_RUN,   1'b0, 0,    0}
  };

  function automatic longint limit_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic reset_model();
    kp_gain   = longint'(KpReset);
    ki_gain   = longint'(KiReset);
    kd_gain   = longint'(KdReset);
    ilim_q8   = longint'(ILimReset);
    trim_us   = longint'(TrimReset);
    pmin_us   = longint'(PMinReset);
    pmax_us   = longint'(PMaxReset);
    clim_us   = longint'(CLimReset);
    roll_zero = 0;
    last_err  = 0;
    integ_q16 = 0;
    held_us   = longint'(HeldReset);
  endtask

  // One control tick: offset, error, PID with anti-windup, pulse clamp
  function automatic servo_out_t pid_step(input logic signed [SampleW-1:0] s,
                                          input logic [PhaseW-1:0] ph);
    longint smp, err, deriv, bound, ctrl, deg, corr, pulse;
    servo_out_t r;
    smp = longint'(s);
    if (ph == PHASE_CAL) roll_zero = smp;
    err = limit_to(-(smp - roll_zero), -65536, 65535);
    deriv = (err - last_err) * TicksPerSec;
    last_err = err;
    integ_q16 = integ_q16 + (ki_gain * err) / TicksPerSec;
    bound = ilim_q8 * 256;
    integ_q16 = limit_to(integ_q16, -bound, bound);
    ctrl = kp_gain * err + integ_q16 + kd_gain * deriv;
    deg = limit_to(ctrl / Q16One, -2048, 2047);
    corr = deg * UsPerDegree;
    // force the integrator once the correction runs past its bound
    if (corr > clim_us) integ_q16 = clim_us * Q16One;
    if (corr < -clim_us) integ_q16 = -clim_us * Q16One;
    pulse = (ph == PHASE_RUN) ? trim_us + corr : held_us;
    if (pulse < pmin_us) pulse = pmin_us;
    if (pulse > pmax_us) pulse = pmax_us;
    held_us = pulse;
    r.pulse = PulseW'(pulse);
    r.deg   = DegW'(deg);
    return r;
  endfunction

  task automatic set_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] word);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= word;
    case (idx)
      CFG_KP:   kp_gain = longint'($signed(word));
      CFG_KI:   ki_gain = longint'($signed(word));
      CFG_KD:   kd_gain = longint'($signed(word));
      CFG_ILIM: ilim_q8 = longint'(word[ILimW-1:0]);
      CFG_TRIM: trim_us = longint'(word[PulseW-1:0]);
      CFG_PMIN: pmin_us = longint'(word[PulseW-1:0]);
      CFG_PMAX: pmax_us = longint'(word[PulseW-1:0]);
      CFG_CLIM: clim_us = longint'(word[PulseW-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_settings(input int kp, input int ki, input int kd, input int ilim,
                               input int trim, input int pmin, input int pmax, input int clim);
    set_reg(CFG_KP, CfgDataW'(kp));
    set_reg(CFG_KI, CfgDataW'(ki));
    set_reg(CFG_KD, CfgDataW'(kd));
    // fill the unused upper bits at random; the block must drop them
    set_reg(CFG_ILIM, {1'($urandom_range(0, 1)), ILimW'(ilim)});
    set_reg(CFG_TRIM, {4'($urandom_range(0, 15)), PulseW'(trim)});
    set_reg(CFG_PMIN, {4'($urandom_range(0, 15)), PulseW'(pmin)});
    set_reg(CFG_PMAX, {4'($urandom_range(0, 15)), PulseW'(pmax)});
    set_reg(CFG_CLIM, {4'($urandom_range(0, 15)), PulseW'(clim)});
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_gain();
    if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 4096)) - 2048;
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample(input int base);
    int pick;
    pick = int'($urandom_range(0, 99));
    if (pick < 15) return SampleW'($urandom_range(0, 131071));
    if (pick < 30) return SampleW'(int'($urandom_range(0, 92160)) - 46080);
    return SampleW'(base + int'($urandom_range(0, 4096)) - 2048);
  endfunction

  function automatic logic [PhaseW-1:0] pick_phase();
    int pick;
    pick = int'($urandom_range(0, 99));
    if (pick < 8) return PHASE_CAL;
    if (pick < 72) return PHASE_RUN;
    if (pick < 88) return PHASE_HOLD;
    return PHASE_SPARE;
  endfunction

  // Offer one request, idling first at random; predict it once it is taken
  task automatic send_request(input logic signed [SampleW-1:0] smp,
                              input logic [PhaseW-1:0] ph,
                              input bit typed, input servo_out_t typed_out);
    servo_out_t due;
    while (int'($urandom_range(0, 99)) < src_idle_pct) begin
      req_ch.valid       <= 1'b0;
      req_ch.roll_sample <= SampleW'($urandom_range(0, 131071));
      req_ch.phase       <= PhaseW'($urandom_range(0, 3));
      @(negedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.roll_sample <= smp;
    req_ch.phase       <= ph;
    do @(posedge clk_i); while (!req_ch.ready);
    due = pid_step(smp, ph);
    pulse_queue.push_back(typed ? typed_out : due);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every outstanding request has its result
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pulse_queue.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_ch.ready <= (int'($urandom_range(0, 99)) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    servo_out_t due;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pulse_queue.size() == 0) begin
        $error("unexpected result: pulse_width %0d, control_degrees %0d",
               rsp_ch.pulse_width, rsp_ch.control_degrees);
        mismatches++;
      end else begin
        due = pulse_queue.pop_front();
        if (rsp_ch.pulse_width !== due.pulse) begin
          $error("pulse_width: expected %0d, got %0d", due.pulse, rsp_ch.pulse_width);
          mismatches++;
        end
        if (rsp_ch.control_degrees !== due.deg) begin
          $error("control_degrees: expected %0d, got %0d", due.deg, rsp_ch.control_degrees);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("roll_pid_servo_controller_core: mismatch");
    $finish;
  end

  initial begin
    servo_out_t                typed_out;
    int                        roll_base;
    int                        k;
    int                        n;
    logic signed [SampleW-1:0] smp;
    logic        [PhaseW-1:0]  ph;

    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_KP;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.roll_sample = '0;
    req_ch.phase       = PHASE_CAL;
    reset_model();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (step_table[i]) begin
      typed_out.pulse = PulseW'(step_table[i].pulse);
      typed_out.deg   = DegW'(step_table[i].deg);
      send_request(SampleW'(step_table[i].sample), step_table[i].ph,
                   step_table[i].typed, typed_out);
    end

    for (k = 0; k < SettingCount; k++) begin
      settle();
      case (k % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 64; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 64; end
        default: begin src_idle_pct = 29; snk_stall_pct = 29; end
      endcase
      case (k)
        0: ;  // keep the reset settings
        1: load_settings(-32768, 32767, -32768, 32767, 4095, 0, 4095, 4095);
        2: load_settings(32767, -32768, 32767, 0, 0, 4095, 0, 0);  // crossed pwm limits
        7: load_settings(-1164, -281, 0, 12800, 1410, 600, 2400, 300);
        default: load_settings(pick_gain(), pick_gain(), pick_gain(),
                               int'($urandom_range(0, 32767)), int'($urandom_range(0, 4095)),
                               int'($urandom_range(0, 2047)), int'($urandom_range(2048, 4095)),
                               int'($urandom_range(0, 4095)));
      endcase
      roll_base = int'($urandom_range(0, 92160)) - 46080;
      for (n = 0; n < ItemsPerSetting; n++) begin
        if (k % 2 == 1 && n == ItemsPerSetting / 2) settle();
        // open each setting with a calibration request
        ph  = (n == 0) ? PHASE_CAL : pick_phase();
        smp = pick_sample(roll_base);
        if (ph == PHASE_CAL) roll_base = int'(smp);
        send_request(smp, ph, 1'b0, typed_out);
      end
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (pulse_queue.size() != 0) begin
      $error("%0d results never arrived", pulse_queue.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("roll_pid_servo_controller_core: match");
    end else begin
      $display("roll_pid_servo_controller_core: mismatch");
    end
    $finish;
  end

endmodule
